// ===== sv/vbc_pkg.sv =====
package vbc_pkg;

  localparam int NBINS          = 16;
  localparam int BIN_W          = 4;
  localparam int ID_W           = 12;
  localparam int CFG_IDX_W      = 8;
  localparam int MAX_BODIES_DEF = 4096;

  localparam logic [4:0]  BIN_NONE     = 5'd31;
  localparam logic [15:0] OVERLAP_DEF  = 16'd52429;
  localparam logic [15:0] MIN_RATIO    = 16'd257;
  localparam logic [4:0]  COUNT_RST    = 5'd16;
  localparam logic [15:0] RATIO_RST    = 16'd512;
  localparam logic [15:0] STEP_RST     = 16'd0;

  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_RATIO   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_OVERLAP = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT  = 8'd3;

  localparam logic [1:0] MOVE_NONE   = 2'd0;
  localparam logic [1:0] MOVE_FASTER = 2'd1;
  localparam logic [1:0] MOVE_SLOWER = 2'd2;

  typedef enum logic [2:0] {
    FN_REBIN,
    FN_CLASSIFY,
    FN_SET_PEAKS,
    FN_RECORD,
    FN_ADVANCE
  } func_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISP,
    ST_RB_SET_CUR,
    ST_RB_SQR_REF,
    ST_RB_SQR_CUR,
    ST_RB_MUL_DIFF,
    ST_RB_STEP,
    ST_RB_MUL_SQ,
    ST_RB_LIMIT,
    ST_RB_INIT,
    ST_RB_DIV1,
    ST_RB_DIV2,
    ST_RB_DIVL,
    ST_RB_NEXT,
    ST_CL_OV,
    ST_CL_OV2,
    ST_CL_MUL,
    ST_CL_CMP,
    ST_CL_NEXT,
    ST_SET_PEAKS,
    ST_RC_UPD,
    ST_AD_INIT,
    ST_AD_SQR,
    ST_AD_MUL,
    ST_AD_ADD,
    ST_AD_NEXT,
    ST_FIN
  } st_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_IDLE,
    OP_RB_SET_CUR,
    OP_RB_SQR_REF,
    OP_RB_SQR_CUR,
    OP_RB_MUL_DIFF,
    OP_RB_STEP,
    OP_RB_MUL_SQ,
    OP_RB_LIMIT,
    OP_RB_INIT,
    OP_RB_DIV1,
    OP_RB_DIV2,
    OP_RB_DIVL,
    OP_BIN_NEXT,
    OP_CL_OV,
    OP_CL_OV2,
    OP_CL_MUL,
    OP_CL_CMP,
    OP_SET_PEAKS,
    OP_RC_UPD,
    OP_AD_INIT,
    OP_AD_SQR,
    OP_AD_MUL,
    OP_AD_ADD,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  in_fire;
    logic  id_ok;
    logic  ref_valid;
    logic  step_zero;
    logic  div_done;
    logic  sqrt_done;
    logic  first_bin;
    logic  last_bin;
    logic  last_used;
    logic  hit;
    logic  over;
    logic  clr_last;
    logic  out_free;
  } sts_t;

endpackage

// ===== sv/vbc_if.sv =====
interface vbc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [11:0] body_id;
  logic [31:0] speed_sq;
  logic [31:0] sweep_length;
  logic [31:0] time_step;

  modport source (output valid, func, body_id, speed_sq, sweep_length, time_step,
                  input ready);
  modport sink (input valid, func, body_id, speed_sq, sweep_length, time_step,
                output ready);
endinterface

interface vbc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  bin_index;
  logic [1:0]  move_kind;
  logic        should_collide;
  logic [31:0] ref_speed_sq;

  modport source (output valid, bin_index, move_kind, should_collide, ref_speed_sq,
                  input ready);
  modport sink (input valid, bin_index, move_kind, should_collide, ref_speed_sq,
                output ready);
endinterface

interface vbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/vbc_div.sv =====
// floor((dvd << 8) / dsr), restoring, one quotient bit per cycle
module vbc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] dvd,
  input  logic [15:0] dsr,
  output logic        done,
  output logic [31:0] quo
);

  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [15:0] rem_r, dsr_r;
  logic [39:0] sh_r;
  logic [16:0] trial;
  logic        ge;

  assign trial = {rem_r, sh_r[39]};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go && !busy_r && !done_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd39) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && !busy_r && !done_r) begin
      sh_r  <= {dvd, 8'd0};
      rem_r <= '0;
      dsr_r <= dsr;
    end else if (busy_r) begin
      rem_r <= ge ? 16'(trial - {1'b0, dsr_r}) : trial[15:0];
      sh_r  <= {sh_r[38:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = sh_r[31:0];

endmodule

// ===== sv/vbc_sqrt.sv =====
// floor(sqrt(rad << 16)), one root bit per cycle
module vbc_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] rad,
  output logic        done,
  output logic [23:0] root
);

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [47:0] v_r, r_r, bit_r;
  logic [47:0] t;

  assign t = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go && !busy_r && !done_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd23) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && !busy_r && !done_r) begin
      v_r   <= {rad, 16'd0};
      r_r   <= '0;
      bit_r <= 48'd1 << 46;
    end else if (busy_r) begin
      if (v_r >= t) begin
        v_r <= v_r - t;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = r_r[23:0];

endmodule

// ===== sv/vbc_ctrl.sv =====
module vbc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  vbc_pkg::sts_t sts,
  output vbc_pkg::cmd_t cmd
);

  vbc_pkg::st_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= vbc_pkg::ST_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      vbc_pkg::ST_CLEAR:       if (sts.clr_last) st_nxt = vbc_pkg::ST_IDLE;
      vbc_pkg::ST_IDLE:        if (sts.in_fire) st_nxt = vbc_pkg::ST_DISP;
      vbc_pkg::ST_DISP: begin
        case (sts.func)
          vbc_pkg::FN_REBIN:
            st_nxt = (!sts.ref_valid || sts.step_zero) ? vbc_pkg::ST_RB_SET_CUR
                                                       : vbc_pkg::ST_RB_SQR_REF;
          vbc_pkg::FN_CLASSIFY:  st_nxt = sts.id_ok ? vbc_pkg::ST_CL_OV : vbc_pkg::ST_FIN;
          vbc_pkg::FN_SET_PEAKS: st_nxt = vbc_pkg::ST_SET_PEAKS;
          vbc_pkg::FN_RECORD:    st_nxt = sts.id_ok ? vbc_pkg::ST_RC_UPD : vbc_pkg::ST_FIN;
          vbc_pkg::FN_ADVANCE:   st_nxt = vbc_pkg::ST_AD_INIT;
          default:               st_nxt = vbc_pkg::ST_FIN;
        endcase
      end
      vbc_pkg::ST_RB_SET_CUR:  st_nxt = vbc_pkg::ST_RB_INIT;
      vbc_pkg::ST_RB_SQR_REF:  if (sts.sqrt_done) st_nxt = vbc_pkg::ST_RB_SQR_CUR;
      vbc_pkg::ST_RB_SQR_CUR:  if (sts.sqrt_done) st_nxt = vbc_pkg::ST_RB_MUL_DIFF;
      vbc_pkg::ST_RB_MUL_DIFF: st_nxt = vbc_pkg::ST_RB_STEP;
      vbc_pkg::ST_RB_STEP:     st_nxt = vbc_pkg::ST_RB_MUL_SQ;
      vbc_pkg::ST_RB_MUL_SQ:   st_nxt = vbc_pkg::ST_RB_LIMIT;
      vbc_pkg::ST_RB_LIMIT:    st_nxt = vbc_pkg::ST_RB_INIT;
      vbc_pkg::ST_RB_INIT:     st_nxt = vbc_pkg::ST_RB_DIV1;
      vbc_pkg::ST_RB_DIV1:     if (sts.div_done) st_nxt = vbc_pkg::ST_RB_DIV2;
      vbc_pkg::ST_RB_DIV2: begin
        if (sts.div_done) st_nxt = sts.first_bin ? vbc_pkg::ST_RB_NEXT : vbc_pkg::ST_RB_DIVL;
      end
      vbc_pkg::ST_RB_DIVL:     if (sts.div_done) st_nxt = vbc_pkg::ST_RB_NEXT;
      vbc_pkg::ST_RB_NEXT:     st_nxt = sts.last_bin ? vbc_pkg::ST_FIN : vbc_pkg::ST_RB_DIV1;
      vbc_pkg::ST_CL_OV:       st_nxt = vbc_pkg::ST_CL_OV2;
      vbc_pkg::ST_CL_OV2:      st_nxt = vbc_pkg::ST_CL_MUL;
      vbc_pkg::ST_CL_MUL:      st_nxt = vbc_pkg::ST_CL_CMP;
      vbc_pkg::ST_CL_CMP: begin
        st_nxt = (sts.hit || sts.last_used) ? vbc_pkg::ST_FIN : vbc_pkg::ST_CL_NEXT;
      end
      vbc_pkg::ST_CL_NEXT:     st_nxt = vbc_pkg::ST_CL_MUL;
      vbc_pkg::ST_SET_PEAKS:   st_nxt = vbc_pkg::ST_FIN;
      vbc_pkg::ST_RC_UPD:      st_nxt = vbc_pkg::ST_FIN;
      vbc_pkg::ST_AD_INIT:     st_nxt = vbc_pkg::ST_AD_SQR;
      vbc_pkg::ST_AD_SQR:      if (sts.sqrt_done) st_nxt = vbc_pkg::ST_AD_MUL;
      vbc_pkg::ST_AD_MUL:      st_nxt = vbc_pkg::ST_AD_ADD;
      vbc_pkg::ST_AD_ADD: begin
        st_nxt = (sts.over || sts.last_used) ? vbc_pkg::ST_FIN : vbc_pkg::ST_AD_NEXT;
      end
      vbc_pkg::ST_AD_NEXT:     st_nxt = vbc_pkg::ST_AD_SQR;
      vbc_pkg::ST_FIN:         if (sts.out_free) st_nxt = vbc_pkg::ST_IDLE;
      default:                 st_nxt = vbc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd.in_ready = 1'b0;
    cmd.op       = vbc_pkg::OP_NONE;
    case (st_r)
      vbc_pkg::ST_CLEAR:       cmd.op = vbc_pkg::OP_CLEAR;
      vbc_pkg::ST_IDLE: begin
        cmd.op       = vbc_pkg::OP_IDLE;
        cmd.in_ready = 1'b1;
      end
      vbc_pkg::ST_DISP:        cmd.op = vbc_pkg::OP_NONE;
      vbc_pkg::ST_RB_SET_CUR:  cmd.op = vbc_pkg::OP_RB_SET_CUR;
      vbc_pkg::ST_RB_SQR_REF:  cmd.op = vbc_pkg::OP_RB_SQR_REF;
      vbc_pkg::ST_RB_SQR_CUR:  cmd.op = vbc_pkg::OP_RB_SQR_CUR;
      vbc_pkg::ST_RB_MUL_DIFF: cmd.op = vbc_pkg::OP_RB_MUL_DIFF;
      vbc_pkg::ST_RB_STEP:     cmd.op = vbc_pkg::OP_RB_STEP;
      vbc_pkg::ST_RB_MUL_SQ:   cmd.op = vbc_pkg::OP_RB_MUL_SQ;
      vbc_pkg::ST_RB_LIMIT:    cmd.op = vbc_pkg::OP_RB_LIMIT;
      vbc_pkg::ST_RB_INIT:     cmd.op = vbc_pkg::OP_RB_INIT;
      vbc_pkg::ST_RB_DIV1:     cmd.op = vbc_pkg::OP_RB_DIV1;
      vbc_pkg::ST_RB_DIV2:     cmd.op = vbc_pkg::OP_RB_DIV2;
      vbc_pkg::ST_RB_DIVL:     cmd.op = vbc_pkg::OP_RB_DIVL;
      vbc_pkg::ST_RB_NEXT:     cmd.op = vbc_pkg::OP_BIN_NEXT;
      vbc_pkg::ST_CL_OV:       cmd.op = vbc_pkg::OP_CL_OV;
      vbc_pkg::ST_CL_OV2:      cmd.op = vbc_pkg::OP_CL_OV2;
      vbc_pkg::ST_CL_MUL:      cmd.op = vbc_pkg::OP_CL_MUL;
      vbc_pkg::ST_CL_CMP:      cmd.op = vbc_pkg::OP_CL_CMP;
      vbc_pkg::ST_CL_NEXT:     cmd.op = vbc_pkg::OP_BIN_NEXT;
      vbc_pkg::ST_SET_PEAKS:   cmd.op = vbc_pkg::OP_SET_PEAKS;
      vbc_pkg::ST_RC_UPD:      cmd.op = vbc_pkg::OP_RC_UPD;
      vbc_pkg::ST_AD_INIT:     cmd.op = vbc_pkg::OP_AD_INIT;
      vbc_pkg::ST_AD_SQR:      cmd.op = vbc_pkg::OP_AD_SQR;
      vbc_pkg::ST_AD_MUL:      cmd.op = vbc_pkg::OP_AD_MUL;
      vbc_pkg::ST_AD_ADD:      cmd.op = vbc_pkg::OP_AD_ADD;
      vbc_pkg::ST_AD_NEXT:     cmd.op = vbc_pkg::OP_BIN_NEXT;
      vbc_pkg::ST_FIN:         cmd.op = vbc_pkg::OP_FIN;
      default:                 cmd.op = vbc_pkg::OP_NONE;
    endcase
  end

endmodule

// ===== sv/vbc_dp.sv =====
module vbc_dp #(
  parameter int MAX_BODIES = vbc_pkg::MAX_BODIES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  vbc_pkg::cmd_t cmd,
  output vbc_pkg::sts_t sts,
  vbc_in_if.sink        in_ch,
  vbc_out_if.source     out_ch,
  vbc_cfg_if.sink       cfg_ch
);

  localparam int ADDR_W = $clog2(MAX_BODIES);
  localparam logic [16:0] BODY_LIM = 17'(MAX_BODIES);
  localparam int NB = vbc_pkg::NBINS;

  // configuration
  logic [4:0]  count_cfg_r;
  logic [15:0] ratio_r, overlap_r, step_r;
  logic [4:0]  n_used;
  logic [15:0] ratio_eff, ov_eff;

  // item
  vbc_pkg::func_t func_r;
  logic [11:0] id_r;
  logic [31:0] sp_r, sweep_r, dt_r;

  // bin state
  logic [31:0] bound_r [NB];
  logic [31:0] limit_r [NB];
  logic [31:0] trav_r  [NB];
  logic [31:0] peak_r  [NB];
  logic [31:0] ref_r;
  logic        ref_valid_r;

  // working registers
  logic [3:0]  bin_r;
  logic [31:0] d_r, l_r;
  logic [23:0] sr_r, sc_r, s_r, spd_r;
  logic [15:0] ov2_r;
  logic [63:0] prod_r;
  logic [3:0]  res_bin_r;
  logic [1:0]  res_move_r;
  logic        res_coll_r;

  // output stage
  logic        out_valid_r;
  logic [3:0]  out_bin_r;
  logic [1:0]  out_move_r;
  logic        out_coll_r;
  logic [31:0] out_ref_r;

  // body table
  logic [4:0]        body_mem [MAX_BODIES];
  logic [4:0]        mem_q_r;
  logic [ADDR_W-1:0] clr_r;
  logic [ADDR_W-1:0] id_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [4:0]        mem_wd;

  logic        in_fire, out_free;
  logic [31:0] mul_a, mul_b;
  logic        sqrt_go, div_go, sqrt_done, div_done;
  logic [31:0] sqrt_in, div_in, quo;
  logic [23:0] root;
  logic [23:0] diff;
  logic        up;
  logic [31:0] lim, sel;
  logic [31:0] thr;
  logic [4:0]  old;
  logic        hit, last_used, over;
  logic [40:0] sum;
  logic [31:0] trav_new;

  assign in_fire     = in_ch.valid && cmd.in_ready;
  assign in_ch.ready = cmd.in_ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign n_used    = (count_cfg_r == 5'd0) ? 5'd1 :
                     (count_cfg_r > 5'(NB)) ? 5'(NB) : count_cfg_r;
  assign ratio_eff = (ratio_r < vbc_pkg::MIN_RATIO) ? vbc_pkg::MIN_RATIO : ratio_r;
  assign ov_eff    = (overlap_r == 16'd0) ? vbc_pkg::OVERLAP_DEF : overlap_r;

  assign id_addr   = ADDR_W'(id_r);
  assign old       = mem_q_r;
  assign last_used = {1'b0, bin_r} == (n_used - 5'd1);

  // rate-limited reference
  assign up   = sc_r >= sr_r;
  assign diff = up ? (sc_r - sr_r) : (sr_r - sc_r);
  assign lim  = prod_r[47:16];
  assign sel  = (sp_r > ref_r) ? ((lim < sp_r) ? lim : sp_r)
                               : ((lim > sp_r) ? lim : sp_r);

  // own bin bound gets the overlap factor, and one bin slower is always allowed
  assign thr = (old == {1'b0, bin_r}) ? prod_r[47:16] : bound_r[bin_r];
  assign hit = ((old != vbc_pkg::BIN_NONE) && (bin_r != 4'd0) &&
                (old == ({1'b0, bin_r} - 5'd1))) || (sp_r >= thr);

  assign sum      = {9'd0, trav_r[bin_r]} + {1'b0, prod_r[55:16]};
  assign trav_new = (sum[40:32] != 9'd0) ? 32'hFFFF_FFFF : sum[31:0];
  assign over     = trav_new > limit_r[bin_r];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      vbc_pkg::OP_RB_MUL_DIFF: begin
        mul_a = {8'd0, diff};
        mul_b = {16'd0, step_r};
      end
      vbc_pkg::OP_RB_MUL_SQ: begin
        mul_a = {8'd0, s_r};
        mul_b = {8'd0, s_r};
      end
      vbc_pkg::OP_CL_OV: begin
        mul_a = {16'd0, ov_eff};
        mul_b = {16'd0, ov_eff};
      end
      vbc_pkg::OP_CL_MUL: begin
        mul_a = bound_r[bin_r];
        mul_b = {16'd0, ov2_r};
      end
      vbc_pkg::OP_AD_MUL: begin
        mul_a = dt_r;
        mul_b = {8'd0, spd_r};
      end
      default: ;
    endcase
  end

  assign sqrt_go = (cmd.op == vbc_pkg::OP_RB_SQR_REF) || (cmd.op == vbc_pkg::OP_RB_SQR_CUR) ||
                   (cmd.op == vbc_pkg::OP_AD_SQR);
  assign sqrt_in = (cmd.op == vbc_pkg::OP_RB_SQR_REF) ? ref_r :
                   (cmd.op == vbc_pkg::OP_RB_SQR_CUR) ? sp_r : peak_r[bin_r];
  assign div_go  = (cmd.op == vbc_pkg::OP_RB_DIV1) || (cmd.op == vbc_pkg::OP_RB_DIV2) ||
                   (cmd.op == vbc_pkg::OP_RB_DIVL);
  assign div_in  = (cmd.op == vbc_pkg::OP_RB_DIVL) ? l_r : d_r;

  vbc_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (sqrt_go),
    .rad  (sqrt_in),
    .done (sqrt_done),
    .root (root)
  );

  vbc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .dvd  (div_in),
    .dsr  (ratio_eff),
    .done (div_done),
    .quo  (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_cfg_r <= vbc_pkg::COUNT_RST;
      ratio_r     <= vbc_pkg::RATIO_RST;
      overlap_r   <= vbc_pkg::OVERLAP_DEF;
      step_r      <= vbc_pkg::STEP_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        vbc_pkg::REG_BIN_COUNT:   count_cfg_r <= cfg_ch.data[4:0];
        vbc_pkg::REG_BIN_RATIO:   ratio_r     <= cfg_ch.data[15:0];
        vbc_pkg::REG_BIN_OVERLAP: overlap_r   <= cfg_ch.data[15:0];
        vbc_pkg::REG_STEP_LIMIT:  step_r      <= cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  // state with defined reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r       <= '0;
      ref_valid_r <= 1'b0;
      bin_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NB; k++) begin
        trav_r[k] <= '0;
        peak_r[k] <= '0;
      end
    end else begin
      case (cmd.op)
        vbc_pkg::OP_CLEAR:     clr_r <= clr_r + ADDR_W'(1);
        vbc_pkg::OP_RB_SET_CUR: begin
          ref_r       <= sp_r;
          ref_valid_r <= 1'b1;
        end
        vbc_pkg::OP_RB_LIMIT:  ref_r <= (sel == 32'd0) ? sp_r : sel;
        vbc_pkg::OP_RB_INIT: begin
          bin_r <= '0;
          for (int k = 0; k < NB; k++) begin
            trav_r[k] <= '0;
            peak_r[k] <= '0;
          end
        end
        vbc_pkg::OP_BIN_NEXT:  bin_r <= bin_r + 4'd1;
        vbc_pkg::OP_CL_OV2:    bin_r <= '0;
        vbc_pkg::OP_AD_INIT:   bin_r <= '0;
        vbc_pkg::OP_SET_PEAKS: begin
          for (int k = 0; k < NB; k++) peak_r[k] <= sp_r;
        end
        vbc_pkg::OP_RC_UPD: begin
          if (!old[4] && (sp_r > peak_r[old[3:0]])) peak_r[old[3:0]] <= sp_r;
        end
        vbc_pkg::OP_AD_ADD:    trav_r[bin_r] <= trav_new;
        default: ;
      endcase
      if (cmd.op == vbc_pkg::OP_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    if (in_fire) begin
      func_r     <= vbc_pkg::func_t'(in_ch.func);
      id_r       <= in_ch.body_id;
      sp_r       <= in_ch.speed_sq;
      sweep_r    <= in_ch.sweep_length;
      dt_r       <= in_ch.time_step;
      res_bin_r  <= '0;
      res_move_r <= vbc_pkg::MOVE_NONE;
      res_coll_r <= 1'b0;
    end
    case (cmd.op)
      vbc_pkg::OP_RB_SQR_REF: if (sqrt_done) sr_r <= root;
      vbc_pkg::OP_RB_SQR_CUR: if (sqrt_done) sc_r <= root;
      vbc_pkg::OP_RB_STEP:    s_r <= up ? (sr_r + prod_r[39:16]) : (sr_r - prod_r[39:16]);
      vbc_pkg::OP_RB_INIT: begin
        d_r <= ref_r;
        l_r <= sweep_r;
      end
      vbc_pkg::OP_RB_DIV1:    if (div_done) d_r <= quo;
      vbc_pkg::OP_RB_DIV2: begin
        if (div_done) begin
          d_r            <= quo;
          bound_r[bin_r] <= last_used ? 32'd0 : quo;
          if (bin_r == 4'd0) limit_r[bin_r] <= (ref_r == 32'd0) ? 32'd0 : sweep_r;
        end
      end
      vbc_pkg::OP_RB_DIVL: begin
        if (div_done) begin
          l_r            <= quo;
          limit_r[bin_r] <= quo;
        end
      end
      vbc_pkg::OP_CL_OV2:     ov2_r <= prod_r[31:16];
      vbc_pkg::OP_CL_CMP: begin
        if (hit || last_used) begin
          res_bin_r <= bin_r;
          if (old != vbc_pkg::BIN_NONE) begin
            if ({1'b0, bin_r} > old)      res_move_r <= vbc_pkg::MOVE_SLOWER;
            else if (old > {1'b0, bin_r}) res_move_r <= vbc_pkg::MOVE_FASTER;
            else                          res_move_r <= vbc_pkg::MOVE_NONE;
          end
        end
      end
      vbc_pkg::OP_AD_SQR:     if (sqrt_done) spd_r <= root;
      vbc_pkg::OP_AD_ADD:     if (over) res_coll_r <= 1'b1;
      default: ;
    endcase
    if (cmd.op == vbc_pkg::OP_FIN && out_free) begin
      out_bin_r  <= res_bin_r;
      out_move_r <= res_move_r;
      out_coll_r <= res_coll_r;
      out_ref_r  <= ref_r;
    end
  end

  // body table: clearing pass after reset, then classify writes
  always_comb begin
    mem_we = 1'b0;
    mem_wa = id_addr;
    mem_wd = {1'b0, bin_r};
    if (cmd.op == vbc_pkg::OP_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
      mem_wd = vbc_pkg::BIN_NONE;
    end else if (cmd.op == vbc_pkg::OP_CL_CMP && (hit || last_used)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) body_mem[mem_wa] <= mem_wd;
    mem_q_r <= body_mem[id_addr];
  end

  assign sts.func      = func_r;
  assign sts.in_fire   = in_fire;
  assign sts.id_ok     = {5'd0, id_r} < BODY_LIM;
  assign sts.ref_valid = ref_valid_r;
  assign sts.step_zero = step_r == 16'd0;
  assign sts.div_done  = div_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.first_bin = bin_r == 4'd0;
  assign sts.last_bin  = bin_r == 4'(NB - 1);
  assign sts.last_used = last_used;
  assign sts.hit       = hit;
  assign sts.over      = over;
  assign sts.clr_last  = clr_r == ADDR_W'(MAX_BODIES - 1);
  assign sts.out_free  = out_free;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.bin_index      = out_bin_r;
  assign out_ch.move_kind      = out_move_r;
  assign out_ch.should_collide = out_coll_r;
  assign out_ch.ref_speed_sq   = out_ref_r;

endmodule

// ===== sv/velocity_bin_classifier_top.sv =====
// work per item: set peaks and record walk no bins, classify walks the bins,
// advance walks the bins with a square root per bin walked,
// rebin makes 47 divisions in the shared divider,
// plus the two square roots when the reference step is limited
// one item at a time; the next item is taken while the previous result waits
// reset: after rst_n every body table entry is swept to unassigned, and no item is taken until the sweep ends
module velocity_bin_classifier_top #(
  parameter int MAX_BODIES = vbc_pkg::MAX_BODIES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  vbc_in_if.sink     in_ch,
  vbc_out_if.source  out_ch,
  vbc_cfg_if.sink    cfg_ch
);

  vbc_pkg::cmd_t cmd;
  vbc_pkg::sts_t sts;

  vbc_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .sts  (sts),
    .cmd  (cmd)
  );

  vbc_dp #(
    .MAX_BODIES(MAX_BODIES)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

endmodule
